// ----- rtl/hue_saturation_to_rgb_led_duty_defines.svh -----
`ifndef HUE_SATURATION_TO_RGB_LED_DUTY_DEFINES_SVH
`define HUE_SATURATION_TO_RGB_LED_DUTY_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define HSRGB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define HSRGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hsrgb_pkg.sv -----
package hsrgb_pkg;

  localparam int GAMMA_TABLE_BITS_DEF = 8;

  // Channels are Q16 with one = 65536, so they need 17 bits
  localparam int CH_W = 17;
  localparam logic [CH_W-1:0] CH_HALF = 17'h08000;

  // Channel times intensity
  localparam int PROD_W = 25;

  // floor(x/255) estimate: (x * ceil(2^23/255)) >> 23, at most one too high
  localparam int RECIP_W = 16;
  localparam logic [RECIP_W-1:0] RECIP_255 = 16'd32897;
  localparam int RECIP_SHIFT = 23;
  localparam int EST_W = PROD_W + RECIP_W;

  typedef enum logic [2:0] {
    SEXT_RED_TO_YELLOW,
    SEXT_YELLOW_TO_GREEN,
    SEXT_GREEN_TO_CYAN,
    SEXT_CYAN_TO_BLUE,
    SEXT_BLUE_TO_MAGENTA,
    SEXT_MAGENTA_TO_RED
  } sextant_t;

  typedef struct packed {
    logic [15:0] hue_angle;
    logic [7:0]  sat_level;
    logic [7:0]  intensity;
  } color_t;

  typedef struct packed {
    logic [7:0] red_duty;
    logic [7:0] green_duty;
    logic [7:0] blue_duty;
  } duty_t;

  // floor(255 * (idx/(2^bits-1))^2.5) in exact integers: largest r with
  // r^2 * (n-1)^5 <= 255^2 * idx^5. Evaluated at elaboration only.
  function automatic logic [7:0] gamma_entry(input int idx, input int bits);
    logic [95:0] n1;
    logic [95:0] x;
    logic [95:0] den;
    logic [95:0] x5;
    logic [95:0] rhs;
    logic [95:0] lhs;
    logic [7:0]  r;
    logic [7:0]  cand;
    n1  = 96'((1 << bits) - 1);
    x   = 96'(idx);
    den = n1 * n1 * n1 * n1 * n1;
    x5  = x * x * x * x * x;
    rhs = 96'd65025 * x5;
    r   = 8'd0;
    for (int b = 7; b >= 0; b--) begin
      cand = r | (8'd1 << b);
      lhs  = 96'(cand) * 96'(cand) * den;
      if (lhs <= rhs) begin
        r = cand;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/hsrgb_stream_if.sv -----
interface hsrgb_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ----- rtl/hue_saturation_to_rgb_led_duty.sv -----
// An accepted color beat moves through the stage registers to its duty beat on the output.
// Throughput: one beat per cycle while the output takes beats; each stage advances on
// its own, so a stalled output holds only the stages behind it until a bubble is found.
// Depth is set by the two chained multiplies of the divide-by-255 scaling and
// the registered gamma table read. Reset (rst, synchronous) clears the valid bits;
// the gamma table is constant logic and needs no fill after reset.
`include "hue_saturation_to_rgb_led_duty_defines.svh"

module hue_saturation_to_rgb_led_duty #(
  parameter int GAMMA_TABLE_BITS = hsrgb_pkg::GAMMA_TABLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  hsrgb_stream_if.sink   color,
  hsrgb_stream_if.source duty
);

  import hsrgb_pkg::*;

  localparam int LutSize = 1 << GAMMA_TABLE_BITS;
  localparam int Stages  = 7;
  localparam int Lanes   = 3;
  localparam int IdxTop  = 15;
  localparam int IdxLow  = 16 - GAMMA_TABLE_BITS;

  logic [Stages:1] vld;
  logic [Stages:1] adv;

  // Gamma table, folded to constants
  logic [7:0] lut [LutSize];
  for (genvar gi = 0; gi < LutSize; gi++) begin : g_lut
    assign lut[gi] = gamma_entry(gi, GAMMA_TABLE_BITS);
  end

  // A stage loads when it is empty or its contents move on
  always_comb begin
    adv[Stages] = !vld[Stages] || duty.ready;
    for (int k = Stages - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign color.ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= color.valid;
      end
      for (int k = 2; k <= Stages; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: half saturation and hue sextant
  logic [14:0] sat128;
  logic [15:0] hs_round;
  logic [15:0] hs_comb;
  logic [18:0] h6;

  logic [15:0] s1_hs;
  sextant_t    s1_sext;
  logic [15:0] s1_frac;
  logic [7:0]  s1_inten;

  always_comb begin
    sat128   = {color.data.sat_level, 7'b0};
    // floor(256*y/255) for a 15-bit y
    hs_round = 16'(sat128) + 16'(sat128 >> 8) + 16'd1;
    hs_comb  = 16'(sat128) + 16'(hs_round[15:8]);
    h6       = 19'({color.data.hue_angle, 2'b0}) + 19'({color.data.hue_angle, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_hs    <= hs_comb;
      s1_sext  <= sextant_t'(h6[18:16]);
      s1_frac  <= h6[15:0];
      s1_inten <= color.data.intensity;
    end
  end

  // Stage 2: ramp offset (v - m) * f
  logic [32:0] vsf_full;

  logic [CH_W-1:0] s2_vsf;
  logic [15:0]     s2_hs;
  sextant_t        s2_sext;
  logic [7:0]      s2_inten;

  assign vsf_full = 33'({s1_hs, 1'b0}) * 33'(s1_frac);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_vsf   <= vsf_full[32:16];
      s2_hs    <= s1_hs;
      s2_sext  <= s1_sext;
      s2_inten <= s1_inten;
    end
  end

  // Stage 3: channel select
  logic [CH_W-1:0] ch_max;
  logic [CH_W-1:0] ch_min;
  logic [CH_W-1:0] mid1;
  logic [CH_W-1:0] mid2;
  logic [CH_W-1:0] ch_sel [Lanes];

  logic [CH_W-1:0] s3_ch [Lanes];
  logic [7:0]      s3_inten;

  always_comb begin
    ch_max = CH_HALF + CH_W'(s2_hs);
    ch_min = CH_HALF - CH_W'(s2_hs);
    mid1   = ch_min + s2_vsf;
    mid2   = ch_max - s2_vsf;
    case (s2_sext)
      SEXT_YELLOW_TO_GREEN: begin
        ch_sel[0] = mid2;   ch_sel[1] = ch_max; ch_sel[2] = ch_min;
      end
      SEXT_GREEN_TO_CYAN: begin
        ch_sel[0] = ch_min; ch_sel[1] = ch_max; ch_sel[2] = mid1;
      end
      SEXT_CYAN_TO_BLUE: begin
        ch_sel[0] = ch_min; ch_sel[1] = mid2;   ch_sel[2] = ch_max;
      end
      SEXT_BLUE_TO_MAGENTA: begin
        ch_sel[0] = mid1;   ch_sel[1] = ch_min; ch_sel[2] = ch_max;
      end
      SEXT_MAGENTA_TO_RED: begin
        ch_sel[0] = ch_max; ch_sel[1] = ch_min; ch_sel[2] = mid2;
      end
      default: begin
        ch_sel[0] = ch_max; ch_sel[1] = mid1;   ch_sel[2] = ch_min;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int l = 0; l < Lanes; l++) begin
        s3_ch[l] <= ch_sel[l];
      end
      s3_inten <= s2_inten;
    end
  end

  // Stage 4: scale by intensity
  logic [PROD_W-1:0] s4_prod [Lanes];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int l = 0; l < Lanes; l++) begin
        s4_prod[l] <= PROD_W'(s3_ch[l]) * PROD_W'(s3_inten);
      end
    end
  end

  // Stage 5: quotient estimate by reciprocal
  logic [EST_W-1:0]  est_full [Lanes];
  logic [CH_W-1:0]   s5_q [Lanes];
  logic [PROD_W-1:0] s5_prod [Lanes];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      est_full[l] = EST_W'(s4_prod[l]) * EST_W'(RECIP_255);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int l = 0; l < Lanes; l++) begin
        s5_q[l]    <= est_full[l][RECIP_SHIFT +: CH_W];
        s5_prod[l] <= s4_prod[l];
      end
    end
  end

  // Stage 6: correct the estimate, form table index
  logic [PROD_W:0]               q_back [Lanes];
  logic [CH_W-1:0]               ch_scaled [Lanes];
  logic [GAMMA_TABLE_BITS-1:0]   idx_comb [Lanes];
  logic [GAMMA_TABLE_BITS-1:0]   s6_idx [Lanes];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      q_back[l] = (PROD_W + 1)'({s5_q[l], 8'b0}) - (PROD_W + 1)'(s5_q[l]);
      if (q_back[l] > (PROD_W + 1)'(s5_prod[l])) begin
        ch_scaled[l] = s5_q[l] - CH_W'(1);
      end else begin
        ch_scaled[l] = s5_q[l];
      end
      // Full channel saturates to the last entry
      if (ch_scaled[l][CH_W-1]) begin
        idx_comb[l] = '1;
      end else begin
        idx_comb[l] = ch_scaled[l][IdxTop:IdxLow];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int l = 0; l < Lanes; l++) begin
        s6_idx[l] <= idx_comb[l];
      end
    end
  end

  // Stage 7: gamma table read into the output register
  logic [7:0] s7_duty [Lanes];

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      for (int l = 0; l < Lanes; l++) begin
        s7_duty[l] <= lut[s6_idx[l]];
      end
    end
  end

  assign duty.valid           = vld[Stages];
  assign duty.data.red_duty   = s7_duty[0];
  assign duty.data.green_duty = s7_duty[1];
  assign duty.data.blue_duty  = s7_duty[2];

  `HSRGB_ASSERT_NEXT(a_accept_fills_stage1, color.valid && color.ready, vld[1],
    "accepted beat did not reach stage 1")

  `HSRGB_ASSERT_NOW(a_ramp_within_span, vld[2], s2_vsf <= CH_W'({s2_hs, 1'b0}),
    "ramp offset exceeds channel span")

  `HSRGB_ASSERT_NOW(a_max_channel_present, vld[3],
    s3_ch[0] >= CH_HALF || s3_ch[1] >= CH_HALF || s3_ch[2] >= CH_HALF,
    "no channel at or above one half")

  `HSRGB_ASSERT_NOW(a_quot_est_bounded, vld[5],
    q_back[0] <= (PROD_W + 1)'(s5_prod[0]) + (PROD_W + 1)'(255),
    "divide-by-255 estimate more than one too high")

endmodule

// ----- verif/tb_hue_saturation_to_rgb_led_duty.sv -----
module tb_hue_saturation_to_rgb_led_duty;
  import hsrgb_pkg::*;

  localparam int TBL_BITS = 8;
  localparam int TBL_SIZE = 1 << TBL_BITS;
  localparam int STALL_LIMIT = 2000;
  localparam int PIPE_DRAIN = 20;
  localparam int ITEMS_PER_PHASE = 185;

  class duty_scoreboard;
    logic [7:0] gamma_curve [TBL_SIZE];
    duty_t      expected_duty [$];
    int         mismatches;

    function new();
      logic [127:0] den;
      logic [127:0] rhs;
      logic [127:0] n1;
      logic [127:0] x;
      int           r;
      n1 = 128'(TBL_SIZE - 1);
      den = n1 * n1 * n1 * n1 * n1;
      r = 0;
      mismatches = 0;
      // Walk up from the previous entry; the curve never decreases
      for (int i = 0; i < TBL_SIZE; i++) begin
        x = 128'(i);
        rhs = 128'd65025 * x * x * x * x * x;
        while (r < 255 && 128'(r + 1) * 128'(r + 1) * den <= rhs) begin
          r++;
        end
        gamma_curve[i] = 8'(r);
      end
    endfunction

    function logic [7:0] channel_duty(logic [16:0] ch, logic [7:0] inten);
      logic [24:0] scaled;
      logic [24:0] idx;
      scaled = (25'(ch) * 25'(inten)) / 25'd255;
      idx = scaled >> (16 - TBL_BITS);
      if (idx > 25'(TBL_SIZE - 1)) begin
        idx = 25'(TBL_SIZE - 1);
      end
      return gamma_curve[idx[TBL_BITS-1:0]];
    endfunction

    function duty_t duty_of_color(color_t c);
      logic [15:0] hs;
      logic [16:0] v;
      logic [16:0] m;
      logic [18:0] h6;
      logic [32:0] ramp;
      logic [16:0] rise;
      logic [16:0] fall;
      logic [16:0] r;
      logic [16:0] g;
      logic [16:0] b;
      duty_t       d;
      hs = 16'((32'(c.sat_level) * 32'd32768) / 32'd255);
      v = CH_HALF + 17'(hs);
      m = CH_HALF - 17'(hs);
      h6 = 19'(c.hue_angle) * 19'd6;
      ramp = (33'(v - m) * 33'(h6[15:0])) >> 16;
      rise = m + 17'(ramp);
      fall = v - 17'(ramp);
      case (sextant_t'(h6[18:16]))
        SEXT_YELLOW_TO_GREEN: begin r = fall; g = v;    b = m;    end
        SEXT_GREEN_TO_CYAN:   begin r = m;    g = v;    b = rise; end
        SEXT_CYAN_TO_BLUE:    begin r = m;    g = fall; b = v;    end
        SEXT_BLUE_TO_MAGENTA: begin r = rise; g = m;    b = v;    end
        SEXT_MAGENTA_TO_RED:  begin r = v;    g = m;    b = fall; end
        default:              begin r = v;    g = rise; b = m;    end
      endcase
      d.red_duty = channel_duty(r, c.intensity);
      d.green_duty = channel_duty(g, c.intensity);
      d.blue_duty = channel_duty(b, c.intensity);
      return d;
    endfunction

    function void note_color(color_t c);
      expected_duty.push_back(duty_of_color(c));
    endfunction

    function void check_duty(duty_t got);
      duty_t want;
      if (expected_duty.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected duty beat r=%0d g=%0d b=%0d",
                   got.red_duty, got.green_duty, got.blue_duty);
        end
        mismatches++;
        return;
      end
      want = expected_duty.pop_front();
      if (got !== want) begin
        if (mismatches < 10) begin
          $display("duty mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want.red_duty, want.green_duty, want.blue_duty,
                   got.red_duty, got.green_duty, got.blue_duty);
        end
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_duty.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  hsrgb_stream_if #(.payload_t(color_t)) color_if ();
  hsrgb_stream_if #(.payload_t(duty_t))  duty_if ();

  hue_saturation_to_rgb_led_duty #(
    .GAMMA_TABLE_BITS(TBL_BITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .color (color_if.sink),
    .duty  (duty_if.source)
  );

  duty_scoreboard sb;
  int unsigned    sender_idle_pct;
  int unsigned    receiver_stall_pct;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      duty_if.ready <= 1'b0;
    end else begin
      duty_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && duty_if.valid && duty_if.ready) begin
      sb.check_duty(duty_if.data);
    end
  end

  // End the run if the channels stop moving
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (color_if.valid && color_if.ready) || (duty_if.valid && duty_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("hue_saturation_to_rgb_led_duty verification failed");
    $finish;
  end

  function automatic color_t mk_color(logic [15:0] hue, logic [7:0] sat, logic [7:0] inten);
    color_t c;
    c.hue_angle = hue;
    c.sat_level = sat;
    c.intensity = inten;
    return c;
  endfunction

  function automatic color_t random_color();
    color_t      c;
    int unsigned k;
    int          edge_idx;
    c.hue_angle = 16'($urandom);
    c.sat_level = 8'($urandom);
    c.intensity = 8'($urandom);
    k = $urandom_range(9);
    if (k == 0) begin
      c.sat_level = $urandom_range(1) ? 8'hFF : 8'h00;
    end else if (k == 1) begin
      c.intensity = $urandom_range(1) ? 8'hFF : 8'h00;
    end else if (k == 2) begin
      // Land close to a sextant boundary
      edge_idx = $urandom_range(6);
      c.hue_angle = 16'((edge_idx * 65536) / 6 + int'($urandom_range(4)) - 2);
    end
    return c;
  endfunction

  task automatic send_color(input color_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      color_if.valid <= 1'b0;
      @(posedge clk);
    end
    color_if.valid <= 1'b1;
    color_if.data <= c;
    @(posedge clk);
    while (!color_if.ready) begin
      @(posedge clk);
    end
    sb.note_color(c);
  endtask

  task automatic hold_until_drained();
    color_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic send_directed();
    // Hue ends, sextant edges, saturation and intensity ends, full channel
    send_color(mk_color(16'd0, 8'd255, 8'd255));
    send_color(mk_color(16'hFFFF, 8'd255, 8'd255));
    send_color(mk_color(16'd0, 8'd0, 8'd0));
    send_color(mk_color(16'hFFFF, 8'd0, 8'd255));
    send_color(mk_color(16'd10922, 8'd255, 8'd255));
    send_color(mk_color(16'd10923, 8'd255, 8'd255));
    send_color(mk_color(16'd21845, 8'd200, 8'd255));
    send_color(mk_color(16'd21846, 8'd200, 8'd128));
    send_color(mk_color(16'd32768, 8'd255, 8'd255));
    send_color(mk_color(16'd43690, 8'd100, 8'd255));
    send_color(mk_color(16'd43691, 8'd100, 8'd77));
    send_color(mk_color(16'd54613, 8'd255, 8'd1));
    send_color(mk_color(16'd54614, 8'd255, 8'd254));
    send_color(mk_color(16'd5461, 8'd128, 8'd255));
    send_color(mk_color(16'd16384, 8'd1, 8'd255));
    send_color(mk_color(16'd27306, 8'd254, 8'd255));
    send_color(mk_color(16'd38229, 8'd255, 8'd0));
    send_color(mk_color(16'd49151, 8'd64, 8'd200));
    send_color(mk_color(16'd60074, 8'd255, 8'd255));
    send_color(mk_color(16'h8000, 8'h80, 8'h80));
    send_color(mk_color(16'h7FFF, 8'h7F, 8'h7F));
  endtask

  initial begin : stimulus
    int unsigned idle_tab [4];
    int unsigned stall_tab [4];
    idle_tab = '{0, 63, 0, 32};
    stall_tab = '{0, 0, 63, 32};
    sb = new();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst = 1'b1;
    color_if.valid = 1'b0;
    color_if.data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_tab[p];
      receiver_stall_pct = stall_tab[p];
      if (p == 0) begin
        send_directed();
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == ITEMS_PER_PHASE / 2) begin
          hold_until_drained();
        end
        send_color(random_color());
      end
      hold_until_drained();
    end

    repeat (PIPE_DRAIN) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("hue_saturation_to_rgb_led_duty verification clean");
    end else begin
      $display("hue_saturation_to_rgb_led_duty verification failed");
    end
    $finish;
  end

endmodule
